>>> rtl/core/shst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spatial hash site table package
// Sizes, hash primes, codes and word layouts shared by the table logic.
// ----------------------------------------------------------------------------
package shst_pkg;

  localparam int INDEX_BITS   = 12;
  localparam int TABLE_SIZE   = 1 << INDEX_BITS;
  localparam int KEY_BITS     = 40;
  localparam int NUMBER_LIMIT = 2048;
  localparam int NUM_W        = 11;
  localparam int COUNT_W      = $clog2(NUMBER_LIMIT + 1);

  localparam logic [63:0] PRIME_X = 64'd73856093;
  localparam logic [63:0] PRIME_Y = 64'd19349663;
  localparam logic [63:0] PRIME_Z = 64'd83492791;

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_INSERT = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_EXHAUSTED = 2'd1,
    STAT_FULL      = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_CHECK,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [KEY_BITS-1:0] z;
    logic [KEY_BITS-1:0] y;
    logic [KEY_BITS-1:0] x;
  } key_t;

  typedef struct packed {
    logic             used;
    logic [NUM_W-1:0] number;
    key_t             key;
  } row_t;

  typedef struct packed {
    status_e          status;
    logic [NUM_W-1:0] number;
    logic             created;
    logic             found;
  } res_t;

endpackage

>>> rtl/core/spatial_hash_site_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spatial hash site table
// Linear-probing hash table mapping a three-coordinate key to a dense number.
// ----------------------------------------------------------------------------
// Channel   Dir  tdata (low bit up)            tuser (low bit up)
// s_axis    in   key_x, key_y, key_z (120 b)   operation
// m_axis    out  site_number, zero pad (16 b)  found, created, status
//
// Slots are probed one per cycle, set by the single read port of the slot
// memory. After reset a clearing pass writes every slot empty; no word is
// accepted during it. A finished result waits in the output register while
// the next word is accepted; a stalled output holds the table in its response
// state until the register frees.
// ----------------------------------------------------------------------------
module spatial_hash_site_table (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [119:0] s_axis_tdata,  // key_x, key_y, key_z
  input  logic [0:0]   s_axis_tuser,  // operation
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [15:0]  m_axis_tdata,  // site_number, zero pad
  output logic [3:0]   m_axis_tuser   // found, created, status
);

  localparam int IB = shst_pkg::INDEX_BITS;

  shst_pkg::state_e        state_q, state_d;
  logic [IB-1:0]           clr_q, clr_d;
  logic [IB-1:0]           addr_q, addr_d;
  logic [IB-1:0]           probe_q, probe_d;
  logic [shst_pkg::COUNT_W-1:0] next_num_q, next_num_d;
  shst_pkg::key_t          key_q;
  shst_pkg::op_e           op_q;
  shst_pkg::res_t          res_q, res_d;
  shst_pkg::res_t          out_res_q;
  logic                    out_valid_q;
  logic                    load_out;

  shst_pkg::row_t          mem [shst_pkg::TABLE_SIZE];
  shst_pkg::row_t          rd_q;
  shst_pkg::row_t          mem_wdata;
  logic                    mem_we, mem_re;
  logic [IB-1:0]           mem_waddr, mem_raddr;

  logic [2*IB-1:0]         px, py, pz;
  logic [IB-1:0]           home;
  logic                    key_match;

  assign px   = key_q.x[IB-1:0] * shst_pkg::PRIME_X[IB-1:0];
  assign py   = key_q.y[IB-1:0] * shst_pkg::PRIME_Y[IB-1:0];
  assign pz   = key_q.z[IB-1:0] * shst_pkg::PRIME_Z[IB-1:0];
  assign home = px[IB-1:0] ^ py[IB-1:0] ^ pz[IB-1:0];

  assign key_match = (rd_q.key == key_q);

  always_comb begin
    state_d       = state_q;
    clr_d         = clr_q;
    addr_d        = addr_q;
    probe_d       = probe_q;
    next_num_d    = next_num_q;
    res_d         = res_q;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_waddr     = addr_q;
    mem_raddr     = addr_q;
    mem_wdata     = '{used: 1'b1, number: next_num_q[shst_pkg::NUM_W-1:0], key: key_q};
    s_axis_tready = 1'b0;
    load_out      = 1'b0;
    unique case (state_q)
      shst_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == '1) begin
          state_d = shst_pkg::ST_IDLE;
        end
      end
      shst_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_d = shst_pkg::ST_HASH;
        end
      end
      shst_pkg::ST_HASH: begin
        mem_re    = 1'b1;
        mem_raddr = home;
        addr_d    = home;
        probe_d   = '0;
        state_d   = shst_pkg::ST_CHECK;
      end
      shst_pkg::ST_CHECK: begin
        res_d = '{status: shst_pkg::STAT_OK, number: '0, created: 1'b0, found: 1'b0};
        if (!rd_q.used) begin
          state_d = shst_pkg::ST_RESP;
          if (op_q == shst_pkg::OP_INSERT) begin
            if (next_num_q >= shst_pkg::COUNT_W'(shst_pkg::NUMBER_LIMIT)) begin
              res_d.status = shst_pkg::STAT_EXHAUSTED;
            end else begin
              mem_we        = 1'b1;
              res_d.created = 1'b1;
              res_d.number  = next_num_q[shst_pkg::NUM_W-1:0];
              next_num_d    = next_num_q + 1'b1;
            end
          end
        end else if (key_match) begin
          state_d      = shst_pkg::ST_RESP;
          res_d.found  = 1'b1;
          res_d.number = rd_q.number;
        end else if (probe_q == '1) begin
          state_d = shst_pkg::ST_RESP;
          if (op_q == shst_pkg::OP_INSERT) begin
            res_d.status = shst_pkg::STAT_FULL;
          end
        end else begin
          probe_d   = probe_q + 1'b1;
          addr_d    = addr_q + 1'b1;
          mem_re    = 1'b1;
          mem_raddr = addr_q + 1'b1;
        end
      end
      shst_pkg::ST_RESP: begin
        if (!out_valid_q || m_axis_tready) begin
          load_out = 1'b1;
          state_d  = shst_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = shst_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= shst_pkg::ST_CLEAR;
      clr_q       <= '0;
      next_num_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      next_num_q <= next_num_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q  <= addr_d;
    probe_q <= probe_d;
    res_q   <= res_d;
    if (s_axis_tvalid && s_axis_tready) begin
      key_q <= s_axis_tdata;
      op_q  <= shst_pkg::op_e'(s_axis_tuser[0]);
    end
    if (load_out) begin
      out_res_q <= res_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[mem_raddr];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(16 - shst_pkg::NUM_W){1'b0}}, out_res_q.number};
  assign m_axis_tuser  = {out_res_q.status, out_res_q.created, out_res_q.found};

  a_no_found_and_created: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(out_res_q.found && out_res_q.created))
    else $error("result both found and created");

  a_created_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_res_q.created) |-> (out_res_q.status == shst_pkg::STAT_OK))
    else $error("created result with error status");

  a_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == shst_pkg::ST_CLEAR || state_q == shst_pkg::ST_CHECK))
    else $error("slot write outside clear or check");

  a_number_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_num_q <= shst_pkg::COUNT_W'(shst_pkg::NUMBER_LIMIT))
    else $error("next number beyond limit");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (next_num_q != $past(next_num_q)) |-> (res_q.created && state_q == shst_pkg::ST_RESP))
    else $error("next number moved without an insert");

endmodule

>>> tb/shst_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spatial hash site table checker
// Keeps a shadow table of slots, keys and site numbers, fed by every word
// accepted on the input channel. Each accepted word yields the answer the
// table owes for it. Output words are compared field by field, in order,
// against the oldest answer still due.
// ----------------------------------------------------------------------------
module shst_checker
  import shst_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [119:0] s_axis_tdata,  // key_x, key_y, key_z
  input  logic [0:0]   s_axis_tuser,  // operation
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [15:0]  m_axis_tdata,  // site_number, zero pad
  input  logic [3:0]   m_axis_tuser,  // found, created, status
  output int           fail_count_o,
  output int           pending_o
);

  logic             slot_taken [TABLE_SIZE];
  key_t             slot_key   [TABLE_SIZE];
  logic [NUM_W-1:0] slot_site  [TABLE_SIZE];
  int unsigned      sites_issued;
  res_t             answers_due [$];

  function automatic logic [63:0] widen_coord(input logic [KEY_BITS-1:0] c);
    return {{(64 - KEY_BITS){c[KEY_BITS-1]}}, c};
  endfunction

  // Probe from the home slot; on an insert, claim the first empty slot while site numbers remain.
  function automatic res_t resolve_site(input op_e op, input key_t k);
    res_t        r;
    logic [63:0] h;
    int          idx;
    bit          done;
    r    = '0;
    done = 1'b0;
    h    = (widen_coord(k.x) * PRIME_X) ^ (widen_coord(k.y) * PRIME_Y) ^
           (widen_coord(k.z) * PRIME_Z);
    for (int p = 0; p < TABLE_SIZE && !done; p++) begin
      idx = (int'(h[INDEX_BITS-1:0]) + p) % TABLE_SIZE;
      if (!slot_taken[idx]) begin
        done = 1'b1;
        if (op == OP_INSERT) begin
          if (sites_issued >= NUMBER_LIMIT) begin
            r.status = STAT_EXHAUSTED;
          end else begin
            slot_taken[idx] = 1'b1;
            slot_key[idx]   = k;
            slot_site[idx]  = NUM_W'(sites_issued);
            r.number        = NUM_W'(sites_issued);
            r.created       = 1'b1;
            sites_issued++;
          end
        end
      end else if (slot_key[idx] == k) begin
        done     = 1'b1;
        r.found  = 1'b1;
        r.number = slot_site[idx];
      end
    end
    if (!done && op == OP_INSERT) r.status = STAT_FULL;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("%0t ns: %s mismatch, got %0h want %0h", $time, what, got, want);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      foreach (slot_taken[i]) slot_taken[i] = 1'b0;
      sites_issued = 0;
      answers_due.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (answers_due.size() == 0) begin
          report_mismatch("unrequested word", {m_axis_tuser, m_axis_tdata[11:0]}, '0);
        end else begin
          want = answers_due.pop_front();
          if (m_axis_tuser[0] !== want.found) begin
            report_mismatch("found", 16'(m_axis_tuser[0]), 16'(want.found));
          end
          if (m_axis_tuser[1] !== want.created) begin
            report_mismatch("created", 16'(m_axis_tuser[1]), 16'(want.created));
          end
          if (m_axis_tdata[NUM_W-1:0] !== want.number) begin
            report_mismatch("site_number", 16'(m_axis_tdata[NUM_W-1:0]),
                            16'(want.number));
          end
          if (m_axis_tuser[3:2] !== want.status) begin
            report_mismatch("status", 16'(m_axis_tuser[3:2]), 16'(want.status));
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        answers_due.push_back(resolve_site(op_e'(s_axis_tuser[0]), key_t'(s_axis_tdata)));
      end
    end
    pending_o = answers_due.size();
  end

endmodule

>>> tb/tb_spatial_hash_site_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spatial hash site table testbench
// Drives lookups and inserts through the table: a short directed run over
// extreme keys, a random mix of new, known and near-miss keys, and a closing
// mix of known and fresh keys. Both channels idle at random; the output is
// once held off long enough to stall the input. A checker beside the table
// predicts and compares every answer.
// ----------------------------------------------------------------------------
module tb_spatial_hash_site_table;
  import shst_pkg::*;

  localparam logic [KEY_BITS-1:0] KEY_MAX = {1'b0, {(KEY_BITS - 1){1'b1}}};
  localparam logic [KEY_BITS-1:0] KEY_MIN = {1'b1, {(KEY_BITS - 1){1'b0}}};
  localparam logic [KEY_BITS-1:0] KEY_ONE = KEY_BITS'(1);
  localparam logic [KEY_BITS-1:0] KEY_ALT = {(KEY_BITS / 2){2'b01}};
  localparam int                  LONG_HOLD = 300;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [119:0] s_axis_tdata;   // key_x, key_y, key_z
  logic [0:0]   s_axis_tuser;   // operation
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [15:0]  m_axis_tdata;   // site_number, zero pad
  logic [3:0]   m_axis_tuser;   // found, created, status
  int           fail_count;
  int           pending;

  key_t site_keys [$];
  int   send_quiet    = 0;
  bit   long_hold_due = 1'b0;

  spatial_hash_site_table dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  shst_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("tb_spatial_hash_site_table NOT OK");
    $finish;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [KEY_BITS-1:0] pick_coord(input bit wide);
    int r;
    r = wide ? 0 : $urandom_range(0, 9);
    if (r < 6) return KEY_BITS'({$urandom, $urandom});
    if (r < 9) return KEY_BITS'(int'($urandom_range(0, 16)) - 8);
    case ($urandom_range(0, 3))
      0: return KEY_MAX;
      1: return KEY_MIN;
      2: return '1;
      default: return '0;
    endcase
  endfunction

  task automatic send_word(input op_e op, input key_t k);
    int gap;
    if (send_quiet > 0) begin
      send_quiet--;
      gap = 0;
    end else begin
      gap = idle_len();
      if ($urandom_range(0, 63) == 0) send_quiet = $urandom_range(20, 80);
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= k;
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    if (op == OP_INSERT) site_keys.push_back(k);
  endtask

  // Key words are {z, y, x}.
  initial begin : stimulus
    key_t k;
    int   r;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= OP_LOOKUP;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_word(OP_LOOKUP, '0);
    send_word(OP_INSERT, '0);
    send_word(OP_LOOKUP, '0);
    send_word(OP_INSERT, '0);
    send_word(OP_INSERT, {KEY_MAX, KEY_MAX, KEY_MAX});
    send_word(OP_INSERT, {KEY_MIN, KEY_MIN, KEY_MIN});
    send_word(OP_INSERT, '1);
    send_word(OP_INSERT, {KEY_MIN, KEY_MAX, {KEY_BITS{1'b1}}});
    send_word(OP_LOOKUP, {KEY_ONE, KEY_MAX, KEY_MIN});
    send_word(OP_INSERT, {3{KEY_ALT}});
    send_word(OP_INSERT, {3{~KEY_ALT}});
    send_word(OP_LOOKUP, {KEY_MAX, KEY_MAX, KEY_MAX});
    send_word(OP_LOOKUP, {KEY_MIN, KEY_MIN, KEY_MIN});
    send_word(OP_LOOKUP, '1);
    send_word(OP_INSERT, {{KEY_BITS{1'b0}}, {KEY_BITS{1'b0}}, KEY_ONE});
    send_word(OP_INSERT, {{KEY_BITS{1'b0}}, KEY_ONE, {KEY_BITS{1'b0}}});
    send_word(OP_INSERT, {KEY_ONE, {KEY_BITS{1'b0}}, {KEY_BITS{1'b0}}});
    send_word(OP_LOOKUP, {{KEY_BITS{1'b0}}, {KEY_BITS{1'b0}}, KEY_ONE});
    send_word(OP_LOOKUP, {3{~KEY_ALT}});
    send_word(OP_INSERT, {KEY_MIN, KEY_MAX, {KEY_BITS{1'b1}}});

    // Mix new keys, known keys and near misses of known keys.
    for (int n = 0; n < 880; n++) begin
      if (n == 300) long_hold_due = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 45) begin
        send_word(OP_INSERT, {pick_coord(1'b0), pick_coord(1'b0), pick_coord(1'b0)});
      end else if (r < 75) begin
        send_word(op_e'($urandom_range(0, 1)), site_keys[$urandom_range(0, site_keys.size() - 1)]);
      end else if (r < 85) begin
        send_word(OP_LOOKUP, {pick_coord(1'b0), pick_coord(1'b0), pick_coord(1'b0)});
      end else begin
        k = site_keys[$urandom_range(0, site_keys.size() - 1)];
        k.x = k.x ^ (KEY_ONE << $urandom_range(0, KEY_BITS - 1));
        send_word(op_e'($urandom_range(0, 1)), k);
      end
    end

    for (int n = 0; n < 100; n++) begin
      if ($urandom_range(0, 1) == 0) begin
        send_word(op_e'($urandom_range(0, 1)), site_keys[$urandom_range(0, site_keys.size() - 1)]);
      end else begin
        send_word(op_e'($urandom_range(0, 1)),
                  {pick_coord(1'b0), pick_coord(1'b0), pick_coord(1'b0)});
      end
    end
    s_axis_tvalid <= 1'b0;

    do @(posedge clk_i); while (pending != 0);
    repeat (40) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_spatial_hash_site_table OK");
    end else begin
      $display("tb_spatial_hash_site_table NOT OK");
    end
    $finish;
  end

  initial begin : sink
    int stall_left;
    int quiet;
    stall_left = 0;
    quiet      = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold_due) begin
        long_hold_due = 1'b0;
        stall_left    = LONG_HOLD;
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        if (quiet > 0) begin
          quiet--;
        end else begin
          stall_left = idle_len();
          if ($urandom_range(0, 63) == 0) quiet = $urandom_range(20, 80);
        end
      end
    end
  end

endmodule
